// File: src/wpqs_pkg.sv
// shared constants, codes and control structs of the weighted priority queue scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wpqs_pkg;

	localparam int MAX_LEVELS_DEF  = 8;
	localparam int MAX_ENTRIES_DEF = 256;

	localparam int OPW   = 2;
	localparam int IDFW  = 8;
	localparam int PRW   = 4;
	localparam int STW   = 3;
	localparam int CFGW  = 4;

	localparam logic [OPW-1:0] OP_PUSH   = 2'd0;
	localparam logic [OPW-1:0] OP_POP    = 2'd1;
	localparam logic [OPW-1:0] OP_REMOVE = 2'd2;
	localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

	localparam logic [STW-1:0] STS_OK      = 3'd0;
	localparam logic [STW-1:0] STS_EMPTY   = 3'd1;
	localparam logic [STW-1:0] STS_BADPRIO = 3'd2;
	localparam logic [STW-1:0] STS_DUP     = 3'd3;
	localparam logic [STW-1:0] STS_NOTQ    = 3'd4;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_FIND,
		S_SERVE,
		S_FETCH,
		S_EXEC,
		S_FIN
	} state_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic start_pop;
		logic set_empty;
		logic find;
		logic serve;
		logic exec;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [OPW-1:0] op;
		logic           total_zero;
		logic           find_hit;
		logic           serve_hit;
		logic           clr_last;
		logic           out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: src/wpqs_if.sv
// request and response channel interfaces of the scheduler
// depends on wpqs_pkg
`timescale 1ns / 1ps
`default_nettype none
interface wpqs_req_if;
	logic                          valid;
	logic                          ready;
	logic [wpqs_pkg::OPW-1:0]      opcode;
	logic [wpqs_pkg::IDFW-1:0]     entry_id;
	logic [wpqs_pkg::PRW-1:0]      priority_req;

	modport source (output valid, output opcode, output entry_id, output priority_req,
		input ready);
	modport sink (input valid, input opcode, input entry_id, input priority_req,
		output ready);
endinterface

interface wpqs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [wpqs_pkg::IDFW-1:0]     popped_id;
	logic [wpqs_pkg::PRW-1:0]      popped_priority;
	logic [wpqs_pkg::STW-1:0]      status;

	modport source (output valid, output popped_id, output popped_priority, output status,
		input ready);
	modport sink (input valid, input popped_id, input popped_priority, input status,
		output ready);
endinterface
`default_nettype wire

// File: src/wpqs_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module wpqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/wpqs_ctrl.sv
// sequencer of the scheduler: clear sweep, dispatch, pop scan, link update, result
// depends on wpqs_pkg
`timescale 1ns / 1ps
`default_nettype none
module wpqs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire wpqs_pkg::stat_t stat,
	output wpqs_pkg::cmd_t       cmd
);
	wpqs_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wpqs_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			wpqs_pkg::S_CLEAR: begin
				if (stat.clr_last) state_nx = wpqs_pkg::S_IDLE;
			end
			wpqs_pkg::S_IDLE: begin
				if (req_valid) state_nx = wpqs_pkg::S_DISPATCH;
			end
			wpqs_pkg::S_DISPATCH: begin
				if (stat.op == wpqs_pkg::OP_POP) begin
					state_nx = stat.total_zero ? wpqs_pkg::S_FIN : wpqs_pkg::S_FIND;
				end else if (stat.op == wpqs_pkg::OP_PUSH || stat.op == wpqs_pkg::OP_REMOVE) begin
					state_nx = wpqs_pkg::S_EXEC;
				end else begin
					state_nx = wpqs_pkg::S_FIN;
				end
			end
			wpqs_pkg::S_FIND: begin
				if (stat.find_hit) state_nx = wpqs_pkg::S_SERVE;
			end
			wpqs_pkg::S_SERVE: begin
				if (stat.serve_hit) state_nx = wpqs_pkg::S_FETCH;
			end
			wpqs_pkg::S_FETCH: state_nx = wpqs_pkg::S_EXEC;
			wpqs_pkg::S_EXEC:  state_nx = wpqs_pkg::S_FIN;
			wpqs_pkg::S_FIN: begin
				if (stat.out_free) state_nx = wpqs_pkg::S_IDLE;
			end
			default: state_nx = wpqs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			wpqs_pkg::S_CLEAR: cmd.clr = 1'b1;
			wpqs_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.accept = req_valid;
			end
			wpqs_pkg::S_DISPATCH: begin
				if (stat.op == wpqs_pkg::OP_POP) begin
					cmd.set_empty = stat.total_zero;
					cmd.start_pop = !stat.total_zero;
				end
			end
			wpqs_pkg::S_FIND:  cmd.find = 1'b1;
			wpqs_pkg::S_SERVE: cmd.serve = 1'b1;
			wpqs_pkg::S_FETCH: cmd = '0;
			wpqs_pkg::S_EXEC:  cmd.exec = 1'b1;
			wpqs_pkg::S_FIN:   cmd.finish = stat.out_free;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// File: src/wpqs_dp.sv
// datapath of the scheduler: level tables, link rams, scan registers, result register
// depends on wpqs_pkg and wpqs_ram
`timescale 1ns / 1ps
`default_nettype none
module wpqs_dp #(
	parameter int MAX_LEVELS  = wpqs_pkg::MAX_LEVELS_DEF,
	parameter int MAX_ENTRIES = wpqs_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wpqs_pkg::cmd_t                cmd,
	output wpqs_pkg::stat_t                    stat,
	input  wire logic [wpqs_pkg::OPW-1:0]      req_opcode,
	input  wire logic [wpqs_pkg::IDFW-1:0]     req_entry_id,
	input  wire logic [wpqs_pkg::PRW-1:0]      req_priority,
	input  wire logic                          cfg_we,
	input  wire logic [wpqs_pkg::CFGW-1:0]     cfg_wdata,
	input  wire logic                          rsp_ready,
	output logic                               rsp_valid,
	output logic      [wpqs_pkg::IDFW-1:0]     rsp_popped_id,
	output logic      [wpqs_pkg::PRW-1:0]      rsp_popped_priority,
	output logic      [wpqs_pkg::STW-1:0]      rsp_status
);
	localparam int IDW = $clog2(MAX_ENTRIES);
	localparam int LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int LCW = $clog2(MAX_LEVELS + 1);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int SW  = $clog2(MAX_LEVELS + 1);
	localparam int LC_RST = (MAX_LEVELS < 8) ? MAX_LEVELS : 8;
	localparam int NIDS = 1 << wpqs_pkg::IDFW;

	logic [IDW-1:0] id_tab [NIDS];
	for (genvar g = 0; g < NIDS; g++) begin : g_idtab
		assign id_tab[g] = IDW'(g % MAX_ENTRIES);
	end

	logic [wpqs_pkg::OPW-1:0] op_q;
	logic [IDW-1:0]           id_q;
	logic [wpqs_pkg::PRW-1:0] prio_q;
	logic [LVW-1:0]           b_q, cursor_q;
	logic [LCW-1:0]           lc_q;
	logic [CW-1:0]            total_q;
	logic [CW-1:0]            held_q [MAX_LEVELS];
	logic [SW-1:0]            served_q [MAX_LEVELS];
	logic [IDW-1:0]           head_q [MAX_LEVELS];
	logic [IDW-1:0]           tail_q [MAX_LEVELS];
	logic [IDW-1:0]           pid_q, clr_cnt_q;
	logic [wpqs_pkg::PRW-1:0] ppr_q;
	logic [wpqs_pkg::STW-1:0] st_q;
	logic                     out_valid_q;

	logic           nx_we, pv_we, inf_we;
	logic [IDW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, inf_wa;
	logic [LVW:0]   inf_wd, inf_rd;
	logic [IDW-1:0] nx_rd, pv_rd;

	wpqs_ram #(.WIDTH(IDW), .DEPTH(MAX_ENTRIES)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(id_q), .rdata(nx_rd));
	wpqs_ram #(.WIDTH(IDW), .DEPTH(MAX_ENTRIES)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(id_q), .rdata(pv_rd));
	wpqs_ram #(.WIDTH(LVW + 1), .DEPTH(MAX_ENTRIES)) u_info (
		.clk(clk), .we(inf_we), .waddr(inf_wa), .wdata(inf_wd), .raddr(id_q), .rdata(inf_rd));

	logic [LVW-1:0] b_dn, push_lv, u_lv;
	logic           u_queued, bad_prio, b_fresh, b_occ, b_alone;
	logic [LCW-1:0] lc_clamp;

	assign b_dn     = (b_q == '0) ? LVW'(lc_q - LCW'(1)) : b_q - LVW'(1);
	assign push_lv  = LVW'(prio_q - wpqs_pkg::PRW'(1));
	assign u_lv     = inf_rd[LVW-1:0];
	assign u_queued = inf_rd[LVW];
	assign bad_prio = (prio_q == '0) || (32'(prio_q) > 32'(lc_q));
	assign b_fresh  = 32'(served_q[b_q]) < (32'(b_q) + 32'd1);
	assign b_occ    = held_q[b_q] != '0;
	assign b_alone  = held_q[b_q] == total_q;

	always_comb begin
		if (cfg_wdata == '0) begin
			lc_clamp = LCW'(1);
		end else if (32'(cfg_wdata) > MAX_LEVELS) begin
			lc_clamp = LCW'(MAX_LEVELS);
		end else begin
			lc_clamp = LCW'(cfg_wdata);
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.total_zero = total_q == '0;
		stat.find_hit   = b_occ;
		stat.serve_hit  = b_fresh ? b_occ : b_alone;
		stat.clr_last   = clr_cnt_q == IDW'(MAX_ENTRIES - 1);
		stat.out_free   = !out_valid_q || rsp_ready;
	end

	// ram write side for link updates and the clear sweep
	always_comb begin
		nx_we  = 1'b0;
		nx_wa  = id_q;
		nx_wd  = id_q;
		pv_we  = 1'b0;
		pv_wa  = id_q;
		pv_wd  = id_q;
		inf_we = 1'b0;
		inf_wa = id_q;
		inf_wd = '0;
		if (cmd.clr) begin
			inf_we = 1'b1;
			inf_wa = clr_cnt_q;
		end else if (cmd.exec) begin
			if (op_q == wpqs_pkg::OP_PUSH) begin
				if (!bad_prio && !u_queued) begin
					inf_we = 1'b1;
					inf_wd = {1'b1, push_lv};
					if (held_q[push_lv] != '0) begin
						nx_we = 1'b1;
						nx_wa = tail_q[push_lv];
						pv_we = 1'b1;
						pv_wd = tail_q[push_lv];
					end
				end
			end else if (op_q == wpqs_pkg::OP_POP || u_queued) begin
				inf_we = 1'b1;
				inf_wd = {1'b0, u_lv};
				if (head_q[u_lv] != id_q) begin
					nx_we = 1'b1;
					nx_wa = pv_rd;
					nx_wd = nx_rd;
				end
				if (tail_q[u_lv] != id_q) begin
					pv_we = 1'b1;
					pv_wa = nx_rd;
					pv_wd = pv_rd;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q        <= LCW'(LC_RST);
			total_q     <= '0;
			cursor_q    <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				held_q[i]   <= '0;
				served_q[i] <= '0;
			end
		end else begin
			if (cfg_we && total_q == '0) lc_q <= lc_clamp;
			if (cmd.clr) clr_cnt_q <= clr_cnt_q + IDW'(1);
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.find && b_occ) cursor_q <= b_q;
			if (cmd.serve) begin
				if (b_fresh) begin
					if (b_occ) served_q[b_q] <= served_q[b_q] + SW'(1);
				end else if (!b_alone) begin
					served_q[b_q] <= '0;
				end
			end
			if (cmd.exec) begin
				if (op_q == wpqs_pkg::OP_PUSH) begin
					if (!bad_prio && !u_queued) begin
						held_q[push_lv] <= held_q[push_lv] + CW'(1);
						total_q         <= total_q + CW'(1);
						if (push_lv > cursor_q) cursor_q <= push_lv;
					end
				end else if (op_q == wpqs_pkg::OP_POP || u_queued) begin
					if (held_q[u_lv] != '0) held_q[u_lv] <= held_q[u_lv] - CW'(1);
					if (total_q != '0) total_q <= total_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= req_opcode;
			id_q   <= id_tab[req_entry_id];
			prio_q <= req_priority;
			pid_q  <= '0;
			ppr_q  <= '0;
			st_q   <= wpqs_pkg::STS_OK;
		end
		if (cmd.set_empty) st_q <= wpqs_pkg::STS_EMPTY;
		if (cmd.start_pop) b_q <= cursor_q;
		if (cmd.find && !b_occ) b_q <= b_dn;
		if (cmd.serve) begin
			if (b_fresh ? b_occ : b_alone) begin
				id_q  <= head_q[b_q];
				pid_q <= head_q[b_q];
				ppr_q <= wpqs_pkg::PRW'(32'(b_q) + 32'd1);
			end else begin
				b_q <= b_dn;
			end
		end
		if (cmd.exec) begin
			if (op_q == wpqs_pkg::OP_PUSH) begin
				if (bad_prio) begin
					st_q <= wpqs_pkg::STS_BADPRIO;
				end else if (u_queued) begin
					st_q <= wpqs_pkg::STS_DUP;
				end else begin
					if (held_q[push_lv] == '0) head_q[push_lv] <= id_q;
					tail_q[push_lv] <= id_q;
				end
			end else if (op_q == wpqs_pkg::OP_POP || u_queued) begin
				if (head_q[u_lv] == id_q) head_q[u_lv] <= nx_rd;
				if (tail_q[u_lv] == id_q) tail_q[u_lv] <= pv_rd;
			end else begin
				st_q <= wpqs_pkg::STS_NOTQ;
			end
		end
		if (cmd.finish) begin
			rsp_popped_id       <= wpqs_pkg::IDFW'(pid_q);
			rsp_popped_priority <= ppr_q;
			rsp_status          <= st_q;
		end
	end

	assign rsp_valid = out_valid_q;
endmodule
`default_nettype wire

// File: src/weighted_priority_queue_scheduler_top.sv
// top level of the weighted priority queue scheduler
// depends on wpqs_pkg, wpqs_if, wpqs_ctrl, wpqs_dp, wpqs_ram
//
//  channel | dir | handshake            | payload
//  req     | in  | valid / ready        | opcode, entry_id, priority_req
//  rsp     | out | valid / ready        | popped_id, popped_priority, status
//  cfg     | in  | cfg_we               | cfg_wdata (level_count)
//
// push and remove pass dispatch and exec, then fin loads the result register;
// a pop passes dispatch, find (skips empty levels), serve (passes exhausted
// levels), fetch and exec; an empty pop goes to fin; req is ready after fin
// after reset a clear sweep runs over all MAX_ENTRIES entries of the entry ram
// before req is ready
// one item at a time; the next item is taken while a result waits in rsp
`timescale 1ns / 1ps
`default_nettype none
module weighted_priority_queue_scheduler_top #(
	parameter int MAX_LEVELS  = wpqs_pkg::MAX_LEVELS_DEF,
	parameter int MAX_ENTRIES = wpqs_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	wpqs_req_if.sink                       req,
	wpqs_rsp_if.source                     rsp,
	input  wire logic                      cfg_we,
	input  wire logic [wpqs_pkg::CFGW-1:0] cfg_wdata
);
	wpqs_pkg::cmd_t  cmd;
	wpqs_pkg::stat_t stat;

	wpqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	wpqs_dp #(.MAX_LEVELS(MAX_LEVELS), .MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.req_opcode          (req.opcode),
		.req_entry_id        (req.entry_id),
		.req_priority        (req.priority_req),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.rsp_ready           (rsp.ready),
		.rsp_valid           (rsp.valid),
		.rsp_popped_id       (rsp.popped_id),
		.rsp_popped_priority (rsp.popped_priority),
		.rsp_status          (rsp.status)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item accepted while another is in progress");

	a_prio_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != wpqs_pkg::STS_OK |-> rsp.popped_priority == '0)
		else $error("priority reported on failed item");

	a_id_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != wpqs_pkg::STS_OK |-> rsp.popped_id == '0)
		else $error("id reported on failed item");
endmodule
`default_nettype wire

// File: tb/weighted_priority_queue_scheduler_top_tb.sv
// testbench of the weighted priority queue scheduler: directed and random items with
// their own result prediction, random idling on both channels, level count changes
// depends on wpqs_pkg, wpqs_if and weighted_priority_queue_scheduler_top
`timescale 1ns / 1ps
module weighted_priority_queue_scheduler_top_tb;

	typedef struct {
		logic [wpqs_pkg::IDFW-1:0] id;
		logic [wpqs_pkg::PRW-1:0]  pr;
		logic [wpqs_pkg::STW-1:0]  st;
	} sched_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [wpqs_pkg::CFGW-1:0] cfg_wdata;

	wpqs_req_if req_ch();
	wpqs_rsp_if rsp_ch();

	weighted_priority_queue_scheduler_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// scheduler image
	logic [7:0] nxt_id [256];
	logic [7:0] prv_id [256];
	int         id_lvl [256];
	bit         id_queued [256];
	logic [7:0] lvl_head [8];
	logic [7:0] lvl_tail [8];
	int         lvl_cnt [8];
	int         lvl_served [8];
	int         held_total;
	int         cursor;
	int         levels_used;

	sched_result_t pending_results[$];
	int  fails;
	bit  idle_on;
	int  stall_left;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int lvl_below(int b);
		return (b == 0) ? levels_used - 1 : b - 1;
	endfunction

	function automatic void unlink_id(int id);
		int lv;
		int p;
		int n;
		lv = id_lvl[id];
		p = prv_id[id];
		n = nxt_id[id];
		if (lvl_head[lv] == id) lvl_head[lv] = n;
		else nxt_id[p] = n;
		if (lvl_tail[lv] == id) lvl_tail[lv] = p;
		else prv_id[n] = p;
		id_queued[id] = 0;
		if (lvl_cnt[lv] > 0) lvl_cnt[lv]--;
		if (held_total > 0) held_total--;
	endfunction

	function automatic sched_result_t schedule_item(logic [wpqs_pkg::OPW-1:0] op,
			logic [wpqs_pkg::IDFW-1:0] id, logic [wpqs_pkg::PRW-1:0] pr);
		sched_result_t r;
		int b;
		int g;
		int lv;
		bit done;
		r.id = '0;
		r.pr = '0;
		r.st = wpqs_pkg::STS_OK;
		if (op == wpqs_pkg::OP_PUSH) begin
			if (pr < 1 || pr > levels_used) begin
				r.st = wpqs_pkg::STS_BADPRIO;
			end else if (id_queued[id]) begin
				r.st = wpqs_pkg::STS_DUP;
			end else begin
				lv = pr - 1;
				if (lvl_cnt[lv] == 0) begin
					lvl_head[lv] = id;
				end else begin
					nxt_id[lvl_tail[lv]] = id;
					prv_id[id] = lvl_tail[lv];
				end
				lvl_tail[lv] = id;
				id_lvl[id] = lv;
				id_queued[id] = 1;
				lvl_cnt[lv]++;
				held_total++;
				if (lv > cursor) cursor = lv;
			end
		end else if (op == wpqs_pkg::OP_POP) begin
			if (held_total == 0) begin
				r.st = wpqs_pkg::STS_EMPTY;
			end else begin
				b = cursor;
				g = 0;
				done = 0;
				while (lvl_cnt[b] == 0 && g < 16) begin
					b = lvl_below(b);
					g++;
				end
				cursor = b;
				for (g = 0; g < 36 && !done; g++) begin
					if (lvl_served[b] < b + 1) begin
						if (lvl_cnt[b] > 0) begin
							r.id = lvl_head[b];
							unlink_id(lvl_head[b]);
							r.pr = b + 1;
							lvl_served[b]++;
							done = 1;
						end else begin
							b = lvl_below(b);
						end
					end else if (lvl_cnt[b] == held_total) begin
						r.id = lvl_head[b];
						unlink_id(lvl_head[b]);
						r.pr = b + 1;
						done = 1;
					end else begin
						lvl_served[b] = 0;
						b = lvl_below(b);
					end
				end
				if (!done) r.st = wpqs_pkg::STS_EMPTY;
			end
		end else if (op == wpqs_pkg::OP_REMOVE) begin
			if (!id_queued[id]) r.st = wpqs_pkg::STS_NOTQ;
			else unlink_id(id);
		end
		return r;
	endfunction

	task automatic send_item(logic [wpqs_pkg::OPW-1:0] op, logic [wpqs_pkg::IDFW-1:0] id,
			logic [wpqs_pkg::PRW-1:0] pr);
		int gap;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.entry_id <= id;
		req_ch.priority_req <= pr;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(schedule_item(op, id, pr));
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_levels(logic [wpqs_pkg::CFGW-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (held_total == 0) levels_used = (v < 1) ? 1 : (v > 8) ? 8 : v;
	endtask

	task automatic empty_queue();
		while (held_total != 0) send_item(wpqs_pkg::OP_POP, $urandom, $urandom);
	endtask

	task automatic random_items(int n);
		int k;
		int sel;
		logic [wpqs_pkg::PRW-1:0] pr;
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			pr = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15)
				: $urandom_range(1, levels_used);
			if (sel < 45)
				send_item(wpqs_pkg::OP_PUSH, ($urandom_range(0, 9) == 0)
					? $urandom_range(0, 255) : $urandom_range(0, 31), pr);
			else if (sel < 83)
				send_item(wpqs_pkg::OP_POP, $urandom, $urandom);
			else if (sel < 97)
				send_item(wpqs_pkg::OP_REMOVE, $urandom_range(0, 31), $urandom);
			else
				send_item(wpqs_pkg::OP_UNUSED, $urandom, $urandom);
		end
	endtask

	task automatic test_status_codes();
		send_item(wpqs_pkg::OP_POP, 8'd0, 4'd0);
		send_item(wpqs_pkg::OP_PUSH, 8'd5, 4'd0);
		send_item(wpqs_pkg::OP_PUSH, 8'd5, 4'd9);
		send_item(wpqs_pkg::OP_PUSH, 8'd5, 4'd15);
		send_item(wpqs_pkg::OP_PUSH, 8'd255, 4'd8);
		send_item(wpqs_pkg::OP_PUSH, 8'd255, 4'd8);
		send_item(wpqs_pkg::OP_PUSH, 8'd255, 4'd0);
		send_item(wpqs_pkg::OP_REMOVE, 8'd0, 4'd0);
		send_item(wpqs_pkg::OP_UNUSED, 8'hff, 4'hf);
		send_item(wpqs_pkg::OP_PUSH, 8'd0, 4'd1);
		send_item(wpqs_pkg::OP_REMOVE, 8'd255, 4'd0);
		send_item(wpqs_pkg::OP_POP, 8'd0, 4'd0);
		send_item(wpqs_pkg::OP_POP, 8'd0, 4'd0);
	endtask

	task automatic test_weighted_serving();
		int k;
		for (k = 0; k < 4; k++) begin
			send_item(wpqs_pkg::OP_PUSH, 8'(16 + k), 4'd1);
			send_item(wpqs_pkg::OP_PUSH, 8'(32 + k), 4'd3);
			send_item(wpqs_pkg::OP_PUSH, 8'(48 + k), 4'd8);
		end
		// middle of a fifo
		send_item(wpqs_pkg::OP_REMOVE, 8'd33, 4'd0);
		empty_queue();
		send_item(wpqs_pkg::OP_POP, 8'd0, 4'd0);
	endtask

	task automatic test_level_count();
		logic [wpqs_pkg::CFGW-1:0] settings [5] = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd8};
		int k;
		for (k = 0; k < 5; k++) begin
			write_levels(settings[k]);
			random_items(60);
			empty_queue();
		end
		// ignored while entries are held
		send_item(wpqs_pkg::OP_PUSH, 8'd7, 4'd2);
		write_levels(4'd1);
		send_item(wpqs_pkg::OP_PUSH, 8'd8, 4'd6);
		empty_queue();
		write_levels(4'd8);
	endtask

	task automatic test_random_traffic();
		random_items(350);
		drain_results();
		idle_on = 0;
		random_items(150);
		empty_queue();
	endtask

	always @(posedge clk) begin
		sched_result_t e;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result id %0d", rsp_ch.popped_id);
				fails++;
			end else begin
				e = pending_results.pop_front();
				if (rsp_ch.popped_id !== e.id) begin
					$error("popped_id expected %0d actual %0d", e.id, rsp_ch.popped_id);
					fails++;
				end
				if (rsp_ch.popped_priority !== e.pr) begin
					$error("popped_priority expected %0d actual %0d", e.pr,
						rsp_ch.popped_priority);
					fails++;
				end
				if (rsp_ch.status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, rsp_ch.status);
					fails++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		#10ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		fails = 0;
		idle_on = 1;
		stall_left = 0;
		held_total = 0;
		cursor = 0;
		levels_used = 8;
		foreach (id_queued[i]) id_queued[i] = 0;
		foreach (lvl_cnt[i]) begin
			lvl_cnt[i] = 0;
			lvl_served[i] = 0;
		end
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = '0;
		req_ch.entry_id = '0;
		req_ch.priority_req = '0;
		rsp_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_status_codes();
		test_weighted_serving();
		test_level_count();
		test_random_traffic();
		drain_results();
		if (fails == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

// File: weighted_priority_queue_scheduler_top.f
src/wpqs_pkg.sv
src/wpqs_if.sv
src/wpqs_ram.sv
src/wpqs_ctrl.sv
src/wpqs_dp.sv
src/weighted_priority_queue_scheduler_top.sv
tb/weighted_priority_queue_scheduler_top_tb.sv
